### src/nfps_pkg.sv
// Package for the NOR flash program/erase sequencer.
// Payload structs, opcodes, status codes, datapath command type. No dependencies.
package nfps_pkg;

  localparam int SectorsDefault = 32;
  localparam logic [22:0] TickMax = 23'h7FFFFF;

  localparam logic [2:0] OP_PROGRAM = 3'd0;
  localparam logic [2:0] OP_ERASE   = 3'd1;
  localparam logic [2:0] OP_RESET   = 3'd2;
  localparam logic [2:0] OP_REPLY   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NOT_ERA = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  localparam logic [2:0] REG_BASE   = 3'd0;
  localparam logic [2:0] REG_SHIFT  = 3'd1;
  localparam logic [2:0] REG_PROT   = 3'd2;
  localparam logic [2:0] REG_KNOWN  = 3'd3;
  localparam logic [2:0] REG_WTO    = 3'd4;
  localparam logic [2:0] REG_ETO    = 3'd5;
  localparam logic [2:0] REG_SETTLE = 3'd6;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [4:0]  first_sector;
    logic [4:0]  last_sector;
    logic [31:0] reply_data;
  } in_item_t;

  typedef struct packed {
    logic        cycle_valid;
    logic        cycle_write;
    logic        cycle_word;
    logic [31:0] cycle_address;
    logic [7:0]  cycle_data;
    logic        done_res;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // what kind of result the datapath should form
  typedef enum logic [3:0] {
    K_WR_BASE   = 4'd0,  // write data to flash_base + offset
    K_WR_SECTOR = 4'd1,  // 0x30 to sector
    K_WR_BYTE   = 4'd2,  // program byte
    K_RD_WORD   = 4'd3,  // check read at target
    K_RD_BYTE   = 4'd4,  // poll byte
    K_RD_SECTOR = 4'd5,  // poll sector
    K_RESET     = 4'd6,  // 0xF0 with done
    K_PLAIN     = 4'd7   // no cycle, done
  } kind_t;

  typedef struct packed {
    logic        emit;
    kind_t       kind;
    logic [11:0] offset;
    logic [7:0]  data;
    logic [1:0]  status;
    logic        last;
    logic [4:0]  sector;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]  byte_index;
    logic        load;
    logic [31:0] address;
    logic [31:0] word;
  } dp_tgt_t;

endpackage

### src/nor_flash_program_erase_sequencer_unit.sv
// Top level of the NOR flash program/erase sequencer.
// An accepted item sets the sequencer state; its first result is then registered into
// the output register, and the rest follow one per clock while the output is not stalled
// and no protected sector is being skipped in an erase sweep (0..37 results). While an
// item's results are being emitted, the input is stalled.
// Synchronous active-high reset: registers to reset values, phase idle, output empty.
module nor_flash_program_erase_sequencer_unit import nfps_pkg::*; #(
  parameter int SECTORS = SectorsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] flash_base, protect_mask, pending_word;
  logic [4:0]  sector_shift;
  logic        device_known;
  logic [15:0] write_timeout;
  logic [21:0] erase_timeout;
  logic [7:0]  settle_ticks;
  dp_cmd_t     cmd;
  dp_tgt_t     tgt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base <= '0;
      sector_shift <= 5'd16;
      protect_mask <= '0;
      device_known <= 1'b0;
      write_timeout <= 16'd500;
      erase_timeout <= 22'd120000;
      settle_ticks <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE:   flash_base <= cfg_data;
        REG_SHIFT:  sector_shift <= cfg_data[4:0];
        REG_PROT:   protect_mask <= cfg_data;
        REG_KNOWN:  device_known <= cfg_data[0];
        REG_WTO:    write_timeout <= cfg_data[15:0];
        REG_ETO:    erase_timeout <= cfg_data[21:0];
        REG_SETTLE: settle_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  nfps_ctrl #(.SECTORS(SECTORS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_item(in_data),
    .protect_mask, .device_known, .write_timeout, .erase_timeout, .settle_ticks,
    .pending_word, .out_full(out_valid), .out_stall, .cmd, .tgt
  );

  nfps_datapath u_dp (
    .clk, .rst, .cmd, .tgt, .flash_base, .sector_shift, .pending_word,
    .out_full(out_valid), .out_item(out_data), .out_stall
  );

endmodule

### src/nfps_datapath.sv
// Datapath: target registers, address/data formation and output register.
// Depends on nfps_pkg.
module nfps_datapath import nfps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  dp_tgt_t     tgt,
  input  logic [31:0] flash_base,
  input  logic [4:0]  sector_shift,
  output logic [31:0] pending_word,
  output logic        out_full,
  output out_item_t   out_item,
  input  logic        out_stall
);

  logic [31:0] target_address;
  logic [31:0] sector_off;
  logic [31:0] byte_addr;
  out_item_t   item_next;

  always_ff @(posedge clk) begin
    if (tgt.load) begin
      target_address <= tgt.address;
      pending_word   <= tgt.word;
    end
  end

  assign sector_off = {27'd0, cmd.sector} << sector_shift;
  assign byte_addr  = target_address + {30'd0, tgt.byte_index};

  always_comb begin
    item_next = '0;
    item_next.last = cmd.last;
    unique case (cmd.kind)
      K_WR_BASE: begin
        item_next.cycle_valid = 1'b1;
        item_next.cycle_write = 1'b1;
        item_next.cycle_address = flash_base + {20'd0, cmd.offset};
        item_next.cycle_data = cmd.data;
      end
      K_WR_SECTOR: begin
        item_next.cycle_valid = 1'b1;
        item_next.cycle_write = 1'b1;
        item_next.cycle_address = flash_base + sector_off;
        item_next.cycle_data = 8'h30;
      end
      K_WR_BYTE: begin
        item_next.cycle_valid = 1'b1;
        item_next.cycle_write = 1'b1;
        item_next.cycle_address = byte_addr;
        item_next.cycle_data = pending_word[8*(3-tgt.byte_index) +: 8];
      end
      K_RD_WORD: begin
        item_next.cycle_valid = 1'b1;
        item_next.cycle_word = 1'b1;
        item_next.cycle_address = target_address;
      end
      K_RD_BYTE: begin
        item_next.cycle_valid = 1'b1;
        item_next.cycle_address = byte_addr;
      end
      K_RD_SECTOR: begin
        item_next.cycle_valid = 1'b1;
        item_next.cycle_address = flash_base + sector_off;
      end
      K_RESET: begin
        item_next.cycle_valid = 1'b1;
        item_next.cycle_write = 1'b1;
        item_next.cycle_address = flash_base;
        item_next.cycle_data = 8'hF0;
        item_next.done_res = 1'b1;
        item_next.status = cmd.status;
      end
      K_PLAIN: begin
        item_next.done_res = 1'b1;
        item_next.status = cmd.status;
      end
      default: item_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.emit) begin
      out_full <= 1'b1;
    end else if (!out_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item <= item_next;
    end
  end

endmodule

### src/nfps_ctrl.sv
// Controller: command phase machine and per-input result sequencer.
// Depends on nfps_pkg; drives nfps_datapath through dp_cmd_t.
module nfps_ctrl import nfps_pkg::*; #(
  parameter int SECTORS = SectorsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  input  logic [31:0] protect_mask,
  input  logic        device_known,
  input  logic [15:0] write_timeout,
  input  logic [21:0] erase_timeout,
  input  logic [7:0]  settle_ticks,
  input  logic [31:0] pending_word,
  input  logic        out_full,
  input  logic        out_stall,
  output dp_cmd_t     cmd,
  output dp_tgt_t     tgt
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_CHECK  = 6'b000010,
    PH_PPOLL  = 6'b000100,
    PH_SETTLE = 6'b001000,
    PH_SNONE  = 6'b010000,
    PH_EPOLL  = 6'b100000
  } phase_t;

  // emission sequencer
  typedef enum logic [5:0] {
    SQ_IDLE = 6'b000001,
    SQ_ONE  = 6'b000010,  // single result pending
    SQ_PROG = 6'b000100,  // 3 unlock writes, byte write, poll read
    SQ_EUNL = 6'b001000,  // 5 erase unlock writes
    SQ_SECT = 6'b010000,  // sector sweep
    SQ_TAIL = 6'b100000   // trailing single result; no transition enters this state
  } seq_t;

  phase_t      phase;
  seq_t        seq;
  logic [1:0]  byte_index;
  logic [22:0] elapsed_ticks;
  logic [4:0]  poll_sector;
  logic [2:0]  step;
  logic [4:0]  scan, scan_last;
  logic        any_prot_clear;
  kind_t       one_kind;
  logic [1:0]  one_status;
  logic        slot_free;
  logic        accept;
  logic [22:0] tick_inc;
  logic [22:0] settle_need;
  logic        unprot;
  logic        poll_ok;

  assign slot_free = !out_full || !out_stall;
  assign in_stall  = (seq != SQ_IDLE);
  assign accept    = in_valid && !in_stall;
  assign tick_inc  = (elapsed_ticks == TickMax) ? elapsed_ticks : elapsed_ticks + 23'd1;
  assign settle_need = (settle_ticks == 8'd0) ? 23'd1 : {15'd0, settle_ticks};
  assign unprot    = !protect_mask[scan];
  assign poll_ok   = (in_item.reply_data[7] == pending_word[8*(3-byte_index) + 7]);

  // any unprotected sector at or beyond a position, up to a given last position
  function automatic logic later_unprot(input logic [31:0] mask, input logic [4:0] from,
                                        input logic [4:0] upto);
    logic r;
    r = 1'b0;
    for (int s = 0; s < 32; s++) begin
      if (s >= from && s <= upto && !mask[s]) r = 1'b1;
    end
    return r;
  endfunction

  logic more_after;
  assign more_after = (scan != scan_last) &&
                      later_unprot(protect_mask, scan + 5'd1, scan_last);

  always_comb begin
    cmd = '0;
    cmd.kind = K_PLAIN;
    cmd.sector = poll_sector;
    tgt = '0;
    tgt.byte_index = byte_index;
    tgt.address = in_item.address;
    tgt.word = in_item.write_data;
    if (accept && in_item.operation == OP_PROGRAM && phase == PH_IDLE) begin
      tgt.load = 1'b1;
    end
    unique case (seq)
      SQ_ONE: begin
        cmd.emit = slot_free;
        cmd.kind = one_kind;
        cmd.status = one_status;
        cmd.last = 1'b1;
      end
      SQ_TAIL: begin
        cmd.emit = slot_free;
        cmd.kind = one_kind;
        cmd.status = one_status;
        cmd.last = 1'b1;
      end
      SQ_PROG: begin
        cmd.emit = slot_free;
        case (step)
          3'd0: begin cmd.kind = K_WR_BASE; cmd.offset = 12'h555; cmd.data = 8'hAA; end
          3'd1: begin cmd.kind = K_WR_BASE; cmd.offset = 12'h2AA; cmd.data = 8'h55; end
          3'd2: begin cmd.kind = K_WR_BASE; cmd.offset = 12'h555; cmd.data = 8'hA0; end
          3'd3: cmd.kind = K_WR_BYTE;
          default: begin cmd.kind = K_RD_BYTE; cmd.last = 1'b1; end
        endcase
      end
      SQ_EUNL: begin
        cmd.emit = slot_free;
        cmd.kind = K_WR_BASE;
        case (step)
          3'd0: begin cmd.offset = 12'h555; cmd.data = 8'hAA; end
          3'd1: begin cmd.offset = 12'h2AA; cmd.data = 8'h55; end
          3'd2: begin cmd.offset = 12'h555; cmd.data = 8'h80; end
          3'd3: begin cmd.offset = 12'h555; cmd.data = 8'hAA; end
          default: begin
            cmd.offset = 12'h2AA; cmd.data = 8'h55;
            cmd.last = !any_prot_clear;
          end
        endcase
      end
      SQ_SECT: begin
        cmd.emit = slot_free && unprot;
        cmd.kind = K_WR_SECTOR;
        cmd.sector = scan;
        // last iff no later unprotected sector in range
        cmd.last = !more_after;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      seq <= SQ_IDLE;
      byte_index <= '0;
      elapsed_ticks <= '0;
      poll_sector <= '0;
      step <= '0;
      scan <= '0;
      scan_last <= '0;
      any_prot_clear <= 1'b0;
      one_kind <= K_PLAIN;
      one_status <= ST_OK;
    end else begin
      unique case (seq)
        SQ_IDLE: begin
          if (accept) begin
            unique case (in_item.operation)
              OP_RESET: begin
                phase <= PH_IDLE; seq <= SQ_ONE; one_kind <= K_RESET; one_status <= ST_OK;
              end
              OP_PROGRAM: if (phase == PH_IDLE) begin
                byte_index <= '0;
                phase <= PH_CHECK; seq <= SQ_ONE; one_kind <= K_RD_WORD;
                one_status <= ST_OK;
              end
              OP_ERASE: if (phase == PH_IDLE) begin
                if (in_item.first_sector > in_item.last_sector ||
                    {27'd0, in_item.last_sector} >= 32'(SECTORS) || !device_known) begin
                  seq <= SQ_ONE; one_kind <= K_PLAIN; one_status <= ST_REJECT;
                end else begin
                  scan <= in_item.first_sector;
                  scan_last <= in_item.last_sector;
                  any_prot_clear <= later_unprot(protect_mask, in_item.first_sector,
                                                 in_item.last_sector);
                  phase <= later_unprot(protect_mask, in_item.first_sector,
                                        in_item.last_sector) ? PH_SETTLE : PH_SNONE;
                  elapsed_ticks <= '0;
                  step <= '0;
                  seq <= SQ_EUNL;
                end
              end
              OP_REPLY: begin
                if (phase == PH_CHECK) begin
                  if ((in_item.reply_data & pending_word) != pending_word) begin
                    phase <= PH_IDLE; seq <= SQ_ONE; one_kind <= K_PLAIN;
                    one_status <= ST_NOT_ERA;
                  end else begin
                    byte_index <= '0; step <= '0; seq <= SQ_PROG;
                    elapsed_ticks <= '0; phase <= PH_PPOLL;
                  end
                end else if (phase == PH_PPOLL) begin
                  if (poll_ok) begin
                    if (byte_index == 2'd3) begin
                      phase <= PH_IDLE; seq <= SQ_ONE; one_kind <= K_RESET;
                      one_status <= ST_OK;
                    end else begin
                      byte_index <= byte_index + 2'd1; step <= '0; seq <= SQ_PROG;
                      elapsed_ticks <= '0;
                    end
                  end else begin
                    seq <= SQ_ONE; one_kind <= K_RD_BYTE;
                  end
                end else if (phase == PH_EPOLL) begin
                  if (in_item.reply_data[7]) begin
                    phase <= PH_IDLE; seq <= SQ_ONE; one_kind <= K_RESET;
                    one_status <= ST_OK;
                  end else begin
                    seq <= SQ_ONE; one_kind <= K_RD_SECTOR;
                  end
                end
              end
              OP_TICK: begin
                if (phase == PH_PPOLL || phase == PH_EPOLL ||
                    phase == PH_SETTLE || phase == PH_SNONE) begin
                  elapsed_ticks <= tick_inc;
                end
                if (phase == PH_PPOLL && tick_inc > {7'd0, write_timeout}) begin
                  phase <= PH_IDLE; seq <= SQ_ONE; one_kind <= K_RESET;
                  one_status <= ST_TIMEOUT;
                end else if (phase == PH_EPOLL && tick_inc > {1'b0, erase_timeout}) begin
                  phase <= PH_IDLE; seq <= SQ_ONE; one_kind <= K_RESET;
                  one_status <= ST_TIMEOUT;
                end else if ((phase == PH_SETTLE || phase == PH_SNONE) &&
                             tick_inc >= settle_need) begin
                  seq <= SQ_ONE; one_status <= ST_OK;
                  if (phase == PH_SNONE) begin
                    phase <= PH_IDLE; one_kind <= K_RESET;
                  end else begin
                    phase <= PH_EPOLL; one_kind <= K_RD_SECTOR; elapsed_ticks <= '0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        SQ_ONE, SQ_TAIL: if (slot_free) seq <= SQ_IDLE;
        SQ_PROG: if (slot_free) begin
          if (step == 3'd4) seq <= SQ_IDLE;
          else step <= step + 3'd1;
        end
        SQ_EUNL: if (slot_free) begin
          if (step == 3'd4) seq <= any_prot_clear ? SQ_SECT : SQ_IDLE;
          else step <= step + 3'd1;
        end
        SQ_SECT: if (slot_free || !unprot) begin
          if (unprot) poll_sector <= scan;
          if (scan == scan_last || (unprot && !more_after)) seq <= SQ_IDLE;
          else scan <= scan + 5'd1;
        end
        default: seq <= SQ_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_emit_idle: assert property (@(posedge clk) disable iff (rst)
    seq == SQ_IDLE |-> !cmd.emit) else $error("emit while sequencer idle");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    seq != SQ_IDLE |-> in_stall) else $error("input taken during emission");
  a_plain_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.kind == K_PLAIN) |=> phase == PH_IDLE)
    else $error("done without cycle left phase active");
`endif

endmodule
